// ----- hw/rtl/gf3_pkg.sv -----
// shared types and constants for the 3x3 gaussian stream filter
package gf3_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROWM1_W  = $clog2(HEIGHT_LIMIT);
    localparam int ROW_W    = ROWM1_W + 1;

    localparam int PIX_W      = 8;
    localparam int FWIDTH_W   = 11;
    localparam int FHEIGHT_W  = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam int VSUM_W = PIX_W + 2;
    localparam int HSUM_W = VSUM_W + 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        t_pixel pixel_in;
        logic   flush;
    } t_in_item;

    typedef struct packed {
        t_pixel pixel_out;
        logic   frame_last;
    } t_out_item;

    // one window column, oldest line on top
    typedef struct packed {
        t_pixel p_top;
        t_pixel p_mid;
        t_pixel p_bot;
    } t_column;

    typedef struct packed {
        t_pixel above;
        t_pixel current;
    } t_line_pair;

    typedef struct packed {
        logic top;
        logic bot;
    } t_row_mask;

endpackage

// ----- hw/rtl/gf3_ram.sv -----
// generic simple dual port ram with registered read
module gf3_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/gf3_cell.sv -----
// one window column cell: holds three pixels and forms the 1-2-1 column sum
module gf3_cell (
    input  logic                 i_clk,
    input  logic                 i_shift,
    input  gf3_pkg::t_column     i_col,
    input  gf3_pkg::t_row_mask   i_row_mask,
    input  logic                 i_col_mask,
    output gf3_pkg::t_column     o_col,
    output logic [gf3_pkg::VSUM_W-1:0] o_vsum
);
    import gf3_pkg::*;

    t_column            r_col;
    logic [VSUM_W-1:0]  top_term;
    logic [VSUM_W-1:0]  bot_term;
    logic [VSUM_W-1:0]  mid_term;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    always_comb begin
        top_term = i_row_mask.top ? '0 : VSUM_W'(r_col.p_top);
        bot_term = i_row_mask.bot ? '0 : VSUM_W'(r_col.p_bot);
        mid_term = {VSUM_W'(r_col.p_mid)} << 1;
        o_vsum   = i_col_mask ? '0 : (top_term + mid_term + bot_term);
    end

    assign o_col = r_col;

endmodule

// ----- hw/rtl/gf3_out_fifo.sv -----
// small result queue feeding the output channel
module gf3_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  gf3_pkg::t_out_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output gf3_pkg::t_out_item  o_data
);
    import gf3_pkg::*;

    t_out_item               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [FIFO_CNT_W-1:0]   r_count;
    logic                    pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/gaussian_3x3_filter_stream_core.sv -----
// top level of the streaming 3x3 gaussian filter
// path: the request that completes a window goes through stage 1, stage 2 and the queue
// (in stream terms the result comes with the request width+1 positions later)
// throughput: 1 request per cycle via line store read-modify-write, until 4 results pend
// reset: synchronous active low; clears position counters and queues, width 640, height 480
// line store and window are not cleared: unwritten entries only reach masked taps
module gaussian_3x3_filter_stream_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  gf3_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output gf3_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_wr_en,
    input  logic [gf3_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gf3_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import gf3_pkg::*;

    localparam int LINE_W = 2 * PIX_W;
    localparam int SUM_W  = HSUM_W + 1;

    // configuration
    logic [FWIDTH_W-1:0]  r_frame_width;
    logic [FHEIGHT_W-1:0] r_frame_height;
    logic [COL_W-1:0]     wm1;
    logic [ROWM1_W-1:0]   hm1;

    // input position
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;

    // request decode
    logic                 in_acc;
    logic                 act;
    logic                 has_out;
    logic                 col_zero;
    t_row_mask            rmask;
    logic                 left_mask;
    logic                 last;
    logic [ROW_W-1:0]     bot_limit;

    // stage 1
    logic                 r_s1_valid;
    logic                 r_s1_has_out;
    t_row_mask            r_s1_rmask;
    logic                 r_s1_left;
    logic                 r_s1_right;
    logic                 r_s1_last;
    t_pixel               r_s1_pix;
    logic [COL_W-1:0]     r_s1_col;
    logic                 r_s1_fwd;
    t_line_pair           r_fwd_data;
    logic [LINE_W-1:0]    ram_dout;
    t_line_pair           line;
    t_line_pair           wr_line;

    // stage 2
    logic                 r_s2_valid;
    t_row_mask            r_s2_rmask;
    logic                 r_s2_left;
    logic                 r_s2_right;
    logic                 r_s2_last;

    // window chain, index 3 is the incoming column
    t_column              w_col [4];
    logic [2:0]           w_col_mask;
    logic [VSUM_W-1:0]    w_vsum [3];
    logic [SUM_W-1:0]     sum;
    t_out_item            push_item;

    // outstanding results
    logic [FIFO_CNT_W-1:0] r_pend;
    logic                  out_acc;
    logic                  res_acc;

    always_comb begin
        if (r_frame_width == '0) begin
            wm1 = '0;
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            wm1 = COL_W'(MAX_WIDTH - 1);
        end else begin
            wm1 = COL_W'(r_frame_width - 1'b1);
        end
        if (r_frame_height == '0) begin
            hm1 = '0;
        end else if (32'(r_frame_height) > HEIGHT_LIMIT) begin
            hm1 = ROWM1_W'(HEIGHT_LIMIT - 1);
        end else begin
            hm1 = ROWM1_W'(r_frame_height - 1'b1);
        end
    end

    // position of the output pixel is one row and one column behind the input,
    // wrapping to the end of the row two lines back at column zero
    always_comb begin
        in_acc    = i_in_valid && o_in_ready;
        col_zero  = (r_col == '0);
        act       = !(i_in_data.flush && (r_row <= ROW_W'(hm1)));
        has_out   = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && !col_zero);
        rmask.top = col_zero ? (r_row == ROW_W'(2)) : (r_row == ROW_W'(1));
        bot_limit = ROW_W'(hm1) + (col_zero ? ROW_W'(2) : ROW_W'(1));
        rmask.bot = (r_row >= bot_limit);
        left_mask = col_zero ? (wm1 == '0) : (r_col == COL_W'(1));
        last      = col_zero && (r_row == bot_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FWIDTH_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FHEIGHT_W-1:0];
                default:          r_frame_width  <= r_frame_width;
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc && act) begin
            if (has_out && last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (r_col == wm1) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // stage 1 and stage 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc && act;
            r_s2_valid <= r_s1_valid && r_s1_has_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_has_out <= has_out;
        r_s1_rmask   <= rmask;
        r_s1_left    <= left_mask;
        r_s1_right   <= col_zero;
        r_s1_last    <= last;
        r_s1_pix     <= i_in_data.flush ? '0 : i_in_data.pixel_in;
        r_s1_col     <= r_col;
        // the ram reads before the write of the same edge lands
        r_s1_fwd     <= r_s1_valid && (r_s1_col == r_col);
        r_fwd_data   <= wr_line;
        r_s2_rmask   <= r_s1_rmask;
        r_s2_left    <= r_s1_left;
        r_s2_right   <= r_s1_right;
        r_s2_last    <= r_s1_last;
    end

    assign line            = r_s1_fwd ? r_fwd_data : t_line_pair'(ram_dout);
    assign wr_line.above   = line.current;
    assign wr_line.current = r_s1_pix;

    gf3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (LINE_W'(wr_line)),
        .i_rd_en   (in_acc && act),
        .i_rd_addr (r_col),
        .o_rd_data (ram_dout)
    );

    assign w_col[3].p_top = line.above;
    assign w_col[3].p_mid = line.current;
    assign w_col[3].p_bot = r_s1_pix;
    assign w_col_mask     = {r_s2_right, 1'b0, r_s2_left};

    for (genvar g = 0; g < 3; g++) begin : g_cells
        gf3_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (r_s1_valid),
            .i_col      (w_col[g+1]),
            .i_row_mask (r_s2_rmask),
            .i_col_mask (w_col_mask[g]),
            .o_col      (w_col[g]),
            .o_vsum     (w_vsum[g])
        );
    end

    // (8*s + 64) >> 7 with s the 1-2-1 sum equals (s + 8) >> 4
    always_comb begin
        sum = SUM_W'(w_vsum[0]) + (SUM_W'(w_vsum[1]) << 1) + SUM_W'(w_vsum[2])
            + SUM_W'(8);
        push_item.pixel_out  = sum[SUM_W-1] ? t_pixel'(255) : sum[SUM_W-2:4];
        push_item.frame_last = r_s2_last;
    end

    gf3_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  (push_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // results in flight plus queued never exceed the queue depth
    assign out_acc    = o_out_valid && i_out_ready;
    assign res_acc    = in_acc && act && has_out;
    assign o_in_ready = (r_pend < FIFO_CNT_W'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + FIFO_CNT_W'(res_acc) - FIFO_CNT_W'(out_acc);
        end
    end

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("outstanding result count above queue depth");

    a_push_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_pend != '0))
        else $error("result pushed without outstanding credit");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && act && has_out && last && !i_cfg_wr_en) |=>
            ((r_col == '0) && (r_row == '0)))
        else $error("position not restarted after last pixel of frame");

    a_last_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> r_s1_has_out)
        else $error("frame end flagged on a request without result");

endmodule
